// ----- hw/rtl/hcc_pkg.sv -----
package hcc_pkg;

  // Number of double rounds applied to every nonce.
  localparam int DOUBLE_ROUNDS = 10;

  // One double round is a column pass and a diagonal pass. Each pass is four
  // add/xor/rotate steps, and every step is one cell of the chain.
  localparam int STEPS_PER_PASS  = 4;
  localparam int PASSES_PER_ROUND = 2;
  localparam int NUM_CELLS = DOUBLE_ROUNDS * PASSES_PER_ROUND * STEPS_PER_PASS;

  localparam int WORD_W  = 32;
  localparam int NUM_WORDS = 16;
  localparam int FIELD_W = 64;
  localparam int KEY_REGS = 4;
  localparam int CFG_INDEX_W = 2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] state_t;
  typedef logic [1:0] phase_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  // Configuration register indexes.
  localparam cfg_index_t REG_KEY_0_7   = 2'd0;
  localparam cfg_index_t REG_KEY_8_15  = 2'd1;
  localparam cfg_index_t REG_KEY_16_23 = 2'd2;
  localparam cfg_index_t REG_KEY_24_31 = 2'd3;

  // The four constant words of the initial state.
  localparam word_t SIGMA_0 = 32'h6170_7865;
  localparam word_t SIGMA_1 = 32'h3320_646e;
  localparam word_t SIGMA_2 = 32'h7962_2d32;
  localparam word_t SIGMA_3 = 32'h6b20_6574;

  // Roles of the four words inside one quarter round.
  localparam logic [1:0] ROLE_A = 2'd0;
  localparam logic [1:0] ROLE_B = 2'd1;
  localparam logic [1:0] ROLE_C = 2'd2;
  localparam logic [1:0] ROLE_D = 2'd3;

  // Step codes within one pass, each with its rotation amount.
  localparam phase_t PH_ROT16 = 2'd0;
  localparam phase_t PH_ROT12 = 2'd1;
  localparam phase_t PH_ROT8  = 2'd2;
  localparam phase_t PH_ROT7  = 2'd3;

  // State word index for a role of quarter round col. On the diagonal pass
  // each row is shifted left by its own row number.
  function automatic logic [3:0] word_index(logic [1:0] role, logic [1:0] col, logic diag);
    logic [1:0] offset;
    offset = diag ? (col + role) : col;
    return {role, offset};
  endfunction

  // Left rotation by the amount that belongs to a step code.
  function automatic word_t rotate_step(word_t x, phase_t phase);
    word_t r;
    unique case (phase)
      PH_ROT16: r = {x[15:0], x[31:16]};
      PH_ROT12: r = {x[19:0], x[31:20]};
      PH_ROT8:  r = {x[23:0], x[31:24]};
      PH_ROT7:  r = {x[24:0], x[31:25]};
      default:  r = x;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/hcc_cell.sv -----
module hcc_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic            diag,
  input  hcc_pkg::phase_t phase,
  input  logic            in_valid,
  input  hcc_pkg::state_t in_state,
  output logic            out_valid,
  output hcc_pkg::state_t out_state
);
  import hcc_pkg::*;

  state_t state_next;

  // One step of all four quarter rounds of a pass: p += q; s = rotl(s ^ p).
  always_comb begin
    logic [1:0] role_p;
    logic [1:0] role_q;
    logic [1:0] role_s;
    logic [3:0] ip;
    logic [3:0] iq;
    logic [3:0] is;
    word_t      sum;
    state_next = in_state;
    role_p = phase[0] ? ROLE_C : ROLE_A;
    role_q = phase[0] ? ROLE_D : ROLE_B;
    role_s = phase[0] ? ROLE_B : ROLE_D;
    for (int j = 0; j < 4; j++) begin
      ip = word_index(role_p, 2'(j), diag);
      iq = word_index(role_q, 2'(j), diag);
      is = word_index(role_s, 2'(j), diag);
      sum = in_state[ip] + in_state[iq];
      state_next[ip] = sum;
      state_next[is] = rotate_step(in_state[is] ^ sum, phase);
    end
  end

  // Stage valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_state <= state_next;
    end
  end

endmodule

// ----- hw/rtl/hchacha20_subkey_derive_core.sv -----
// HChaCha20 subkey derivation. The 256-bit key is written through the
// configuration port (index 0 holds key bytes 0-7, up to index 3 for bytes
// 24-31). The user must write it only while the core is idle; the core does
// not enforce this. Each nonce transfer enters a chain of 80 registered
// cells (eight per double round, one add/xor/rotate step of the four quarter
// rounds in each); the core takes a new nonce in every cycle unless stalled.
// The chain moves as one: while a finished subkey waits at the output under
// stall, every stage holds and the input is stalled too.
module hchacha20_subkey_derive_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  hcc_pkg::cfg_index_t        cfg_index,
  input  logic [63:0]                cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [63:0]                nonce_bytes_0_7,
  input  logic [63:0]                nonce_bytes_8_15,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [63:0]                subkey_bytes_0_7,
  output logic [63:0]                subkey_bytes_8_15,
  output logic [63:0]                subkey_bytes_16_23,
  output logic [63:0]                subkey_bytes_24_31
);
  import hcc_pkg::*;

  logic [FIELD_W-1:0] key [KEY_REGS];
  logic               advance;
  state_t             start_state;
  logic               valid_chain [NUM_CELLS+1];
  state_t             state_chain [NUM_CELLS+1];

  // Key registers; every write is accepted at once.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < KEY_REGS; k++) begin
        key[k] <= '0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KEY_0_7:   key[0] <= cfg_data;
        REG_KEY_8_15:  key[1] <= cfg_data;
        REG_KEY_16_23: key[2] <= cfg_data;
        REG_KEY_24_31: key[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // The chain holds while a result waits at the output.
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  // Initial state: constants, key words, nonce words.
  always_comb begin
    start_state[0] = SIGMA_0;
    start_state[1] = SIGMA_1;
    start_state[2] = SIGMA_2;
    start_state[3] = SIGMA_3;
    for (int k = 0; k < KEY_REGS; k++) begin
      start_state[4 + 2 * k] = key[k][WORD_W-1:0];
      start_state[5 + 2 * k] = key[k][FIELD_W-1:WORD_W];
    end
    start_state[12] = nonce_bytes_0_7[WORD_W-1:0];
    start_state[13] = nonce_bytes_0_7[FIELD_W-1:WORD_W];
    start_state[14] = nonce_bytes_8_15[WORD_W-1:0];
    start_state[15] = nonce_bytes_8_15[FIELD_W-1:WORD_W];
  end

  assign valid_chain[0] = in_valid;
  assign state_chain[0] = start_state;

  // Chain of round-step cells.
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    localparam phase_t CELL_PHASE = phase_t'(i % STEPS_PER_PASS);
    localparam logic   CELL_DIAG  = 1'((i / STEPS_PER_PASS) % PASSES_PER_ROUND);

    hcc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .diag      (CELL_DIAG),
      .phase     (CELL_PHASE),
      .in_valid  (valid_chain[i]),
      .in_state  (state_chain[i]),
      .out_valid (valid_chain[i+1]),
      .out_state (state_chain[i+1])
    );
  end

  // Subkey from words 0-3 and 12-15 of the last stage.
  assign out_valid          = valid_chain[NUM_CELLS];
  assign subkey_bytes_0_7   = {state_chain[NUM_CELLS][1],  state_chain[NUM_CELLS][0]};
  assign subkey_bytes_8_15  = {state_chain[NUM_CELLS][3],  state_chain[NUM_CELLS][2]};
  assign subkey_bytes_16_23 = {state_chain[NUM_CELLS][13], state_chain[NUM_CELLS][12]};
  assign subkey_bytes_24_31 = {state_chain[NUM_CELLS][15], state_chain[NUM_CELLS][14]};

endmodule

// ----- tb/sv/hcc_subkey_check_pkg.sv -----
package hcc_subkey_check_pkg;

  import hcc_pkg::*;

  // One derived subkey, index 0 holding bytes 0-7 and index 3 bytes 24-31.
  typedef logic [3:0][63:0] subkey_t;

  class subkey_scoreboard;

    logic [63:0] key_reg [KEY_REGS];
    subkey_t     pending_subkeys [$];
    int          mismatches;
    int          subkeys_checked;
    string       field_name [4] = '{"subkey_bytes_0_7", "subkey_bytes_8_15",
                                    "subkey_bytes_16_23", "subkey_bytes_24_31"};

    function new();
      foreach (key_reg[k]) key_reg[k] = '0;
      mismatches      = 0;
      subkeys_checked = 0;
    endfunction

    // Key registers follow every accepted configuration transfer.
    function void write_key(cfg_index_t index, logic [63:0] value);
      key_reg[index] = value;
    endfunction

    function int pending();
      return pending_subkeys.size();
    endfunction

    function word_t rotl32(word_t x, int n);
      return (x << n) | (x >> (WORD_W - n));
    endfunction

    // Add, xor and rotate on the four words of one quarter round.
    function state_t quarter_round(state_t s, int a, int b, int c, int d);
      s[a] = s[a] + s[b]; s[d] = rotl32(s[d] ^ s[a], 16);
      s[c] = s[c] + s[d]; s[b] = rotl32(s[b] ^ s[c], 12);
      s[a] = s[a] + s[b]; s[d] = rotl32(s[d] ^ s[a], 8);
      s[c] = s[c] + s[d]; s[b] = rotl32(s[b] ^ s[c], 7);
      return s;
    endfunction

    // Builds the initial state from the constants, the key and the nonce,
    // runs the double rounds and keeps the first and last rows.
    function subkey_t derive_subkey(logic [63:0] nonce_lo, logic [63:0] nonce_hi);
      state_t s;
      s[0] = SIGMA_0;
      s[1] = SIGMA_1;
      s[2] = SIGMA_2;
      s[3] = SIGMA_3;
      for (int k = 0; k < KEY_REGS; k++) begin
        s[4 + 2 * k] = key_reg[k][31:0];
        s[5 + 2 * k] = key_reg[k][63:32];
      end
      s[12] = nonce_lo[31:0];
      s[13] = nonce_lo[63:32];
      s[14] = nonce_hi[31:0];
      s[15] = nonce_hi[63:32];
      for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
        s = quarter_round(s, 0, 4, 8, 12);
        s = quarter_round(s, 1, 5, 9, 13);
        s = quarter_round(s, 2, 6, 10, 14);
        s = quarter_round(s, 3, 7, 11, 15);
        s = quarter_round(s, 0, 5, 10, 15);
        s = quarter_round(s, 1, 6, 11, 12);
        s = quarter_round(s, 2, 7, 8, 13);
        s = quarter_round(s, 3, 4, 9, 14);
      end
      return {s[15], s[14], s[13], s[12], s[3], s[2], s[1], s[0]};
    endfunction

    // Every accepted nonce yields exactly one subkey.
    function void note_nonce(logic [63:0] nonce_lo, logic [63:0] nonce_hi);
      pending_subkeys.push_back(derive_subkey(nonce_lo, nonce_hi));
    endfunction

    // Compares a delivered subkey with the oldest one still pending.
    function void check_subkey(subkey_t got);
      subkey_t want;
      bit      bad;
      if (pending_subkeys.size() == 0) begin
        if (mismatches < 10)
          $display("ERROR: subkey %h delivered with none pending", got);
        mismatches++;
        return;
      end
      want = pending_subkeys.pop_front();
      subkeys_checked++;
      bad = 0;
      for (int f = 0; f < 4; f++) begin
        if (got[f] !== want[f]) begin
          bad = 1;
          if (mismatches < 10)
            $display("ERROR: subkey %0d %s: wanted %h, got %h",
                     subkeys_checked, field_name[f], want[f], got[f]);
        end
      end
      if (bad) mismatches++;
    endfunction

  endclass

endpackage

// ----- tb/sv/testbench.sv -----
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import hcc_pkg::*;
  import hcc_subkey_check_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_index_t  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] nonce_bytes_0_7;
  logic [63:0] nonce_bytes_8_15;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] subkey_bytes_0_7;
  logic [63:0] subkey_bytes_8_15;
  logic [63:0] subkey_bytes_16_23;
  logic [63:0] subkey_bytes_24_31;

  subkey_scoreboard sb = new();

  int nonce_idle_pct;
  int out_stall_pct;
  int nonces_sent;
  int key_settings;

  hchacha20_subkey_derive_core i_dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .nonce_bytes_0_7    (nonce_bytes_0_7),
    .nonce_bytes_8_15   (nonce_bytes_8_15),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .subkey_bytes_0_7   (subkey_bytes_0_7),
    .subkey_bytes_8_15  (subkey_bytes_8_15),
    .subkey_bytes_16_23 (subkey_bytes_16_23),
    .subkey_bytes_24_31 (subkey_bytes_24_31)
  );

  // Free-running clock, 20 ns period.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Output back-pressure, redrawn at every falling edge.
  always @(negedge clk) begin
    out_stall = rst ? 1'b0 : ($urandom_range(99) < out_stall_pct);
  end

  // Every subkey transfer is checked against the oldest pending prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_subkey({subkey_bytes_24_31, subkey_bytes_16_23,
                       subkey_bytes_8_15, subkey_bytes_0_7});
  end

  // Hard stop in case the block hangs.
  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  // Mostly full-width random values, with zero, all ones and single bits mixed in.
  function automatic logic [63:0] random_field();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      2:       return 64'h1 << $urandom_range(63);
      3:       return ~(64'h1 << $urandom_range(63));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offers one nonce, with random gaps first, and waits for its transfer.
  task automatic send_nonce(input logic [63:0] lo, input logic [63:0] hi);
    while ($urandom_range(99) < nonce_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid         = 1'b1;
    nonce_bytes_0_7  = lo;
    nonce_bytes_8_15 = hi;
    do @(posedge clk); while (in_stall);
    sb.note_nonce(lo, hi);
    nonces_sent++;
    @(negedge clk);
  endtask

  task automatic write_cfg(input cfg_index_t index, input logic [63:0] value);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_key(index, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_key(input logic [63:0] k0, input logic [63:0] k1,
                          input logic [63:0] k2, input logic [63:0] k3);
    write_cfg(REG_KEY_0_7, k0);
    write_cfg(REG_KEY_8_15, k1);
    write_cfg(REG_KEY_16_23, k2);
    write_cfg(REG_KEY_24_31, k3);
    key_settings++;
  endtask

  // Stops offering nonces and waits for every pending subkey, with a limit.
  task automatic drain(input int max_cycles);
    int waited;
    in_valid = 1'b0;
    waited   = 0;
    while (sb.pending() > 0 && waited < max_cycles) begin
      @(negedge clk);
      waited++;
    end
    repeat (4) @(negedge clk);
  endtask

  initial begin
    cfg_valid        = 1'b0;
    cfg_index        = REG_KEY_0_7;
    cfg_data         = '0;
    in_valid         = 1'b0;
    nonce_bytes_0_7  = '0;
    nonce_bytes_8_15 = '0;
    nonce_idle_pct   = 0;
    out_stall_pct    = 0;
    nonces_sent      = 0;
    key_settings     = 0;
    rst              = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Key left at its reset value of zero, field extremes on the nonce.
    send_nonce('0, '0);
    send_nonce('1, '1);
    send_nonce(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    send_nonce(64'h1, 64'h8000_0000_0000_0000);
    send_nonce(64'h8000_0000_0000_0000, 64'h1);
    drain(1000);

    // The published test key, bytes 00 to 1f, and its test nonce.
    load_key(64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908,
             64'h1716_1514_1312_1110, 64'h1f1e_1d1c_1b1a_1918);
    send_nonce(64'h4a00_0000_0900_0000, 64'h2759_4131_0000_0000);
    send_nonce('0, '1);
    send_nonce('1, '0);
    drain(1000);

    // All-ones key.
    load_key('1, '1, '1, '1);
    send_nonce('0, '0);
    send_nonce('1, '1);
    send_nonce(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    drain(1000);

    // All four key words mixed: alternating bit patterns, zero and a single bit.
    load_key(64'haaaa_aaaa_aaaa_aaaa, 64'h0, 64'h5555_5555_5555_5555, 64'h1);
    send_nonce(64'h0000_0001_0000_0000, 64'h0000_0000_8000_0000);
    send_nonce('1, 64'h0);
    drain(1000);

    // Random traffic in three idling mixes, a fresh key for every phase.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin
          nonce_idle_pct = 38;
          out_stall_pct  = 56;
        end
        1: begin
          nonce_idle_pct = 56;
          out_stall_pct  = 38;
        end
        default: begin
          nonce_idle_pct = 0;
          out_stall_pct  = 0;
        end
      endcase
      load_key(random_field(), random_field(), random_field(), random_field());
      repeat (305) send_nonce(random_field(), random_field());
      drain(1000);
    end

    // Final flush: anything still pending is a missing subkey.
    drain(20000);
    repeat (100) @(negedge clk);
    if (sb.pending() != 0) begin
      $display("ERROR: %0d subkeys never delivered", sb.pending());
      sb.mismatches += sb.pending();
    end

    $display("Checked %0d subkeys from %0d nonce transfers under %0d key settings,",
             sb.subkeys_checked, nonces_sent, key_settings + 1);
    $display("with sender gaps and output stalls in three mixes; %0d mismatches.",
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- hchacha20_subkey_derive_core.f -----
hw/rtl/hcc_pkg.sv
hw/rtl/hcc_cell.sv
hw/rtl/hchacha20_subkey_derive_core.sv
tb/sv/hcc_subkey_check_pkg.sv
tb/sv/testbench.sv
